### src/sha1bsh_pkg.sv
// shared types and constants for the sha-1 byte stream hasher
package sha1bsh_pkg;

    localparam int WORD_W     = 32;
    localparam int SCHED_DEPTH = 16;
    localparam int SCHED_AW   = 4;
    localparam int ROUND_W    = 7;
    localparam int CHAIN_N    = 5;

    localparam logic [ROUND_W-1:0] ROUND_LAST = 7'd79;

    // initial chaining values
    localparam logic [WORD_W-1:0] IV_0 = 32'h6745_2301;
    localparam logic [WORD_W-1:0] IV_1 = 32'hEFCD_AB89;
    localparam logic [WORD_W-1:0] IV_2 = 32'h98BA_DCFE;
    localparam logic [WORD_W-1:0] IV_3 = 32'h1032_5476;
    localparam logic [WORD_W-1:0] IV_4 = 32'hC3D2_E1F0;

    // round constants
    localparam logic [WORD_W-1:0] K_0 = 32'h5A82_7999;
    localparam logic [WORD_W-1:0] K_1 = 32'h6ED9_EBA1;
    localparam logic [WORD_W-1:0] K_2 = 32'h8F1B_BCDC;
    localparam logic [WORD_W-1:0] K_3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    // schedule taps read for one round: t-3, t-8, t-14, t-16 (mod 16)
    typedef logic [3:0][WORD_W-1:0] sched_taps_t;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic               load_work;
        logic               round_en;
        logic [ROUND_W-1:0] round_idx;
        logic               add_chain;
        logic               restore_iv;
    } core_ctrl_t;

endpackage

### src/sha1bsh_ram.sv
// generic ram: one write port, two registered read ports
module sha1bsh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered reads
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

### src/sha1bsh_core.sv
// sha-1 round datapath: working variables, chaining words, schedule expansion
module sha1bsh_core (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  sha1bsh_pkg::core_ctrl_t               ctrl,
    input  sha1bsh_pkg::sched_taps_t              taps,
    input  logic [2:0]                            out_sel,
    output logic [sha1bsh_pkg::WORD_W-1:0]        sched_word,
    output logic [sha1bsh_pkg::WORD_W-1:0]        chain_word
);
    import sha1bsh_pkg::*;

    logic [WORD_W-1:0] work_reg  [CHAIN_N];
    logic [WORD_W-1:0] chain_reg [CHAIN_N];
    logic [WORD_W-1:0] mix;
    logic [WORD_W-1:0] f_val;
    logic [WORD_W-1:0] k_val;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] wa, wb, wc, wd, we_w;

    assign wa   = work_reg[0];
    assign wb   = work_reg[1];
    assign wc   = work_reg[2];
    assign wd   = work_reg[3];
    assign we_w = work_reg[4];

    // message schedule word for this round
    assign mix = taps[0] ^ taps[1] ^ taps[2] ^ taps[3];
    assign sched_word = (ctrl.round_idx < 7'd16) ? taps[3] : {mix[WORD_W-2:0], mix[WORD_W-1]};

    // round function and constant
    always_comb
    begin
        priority if (ctrl.round_idx < 7'd20)
        begin
            f_val = (wb & wc) | (~wb & wd);
            k_val = K_0;
        end
        else if (ctrl.round_idx < 7'd40)
        begin
            f_val = wb ^ wc ^ wd;
            k_val = K_1;
        end
        else if (ctrl.round_idx < 7'd60)
        begin
            f_val = (wb & wc) | (wb & wd) | (wc & wd);
            k_val = K_2;
        end
        else
        begin
            f_val = wb ^ wc ^ wd;
            k_val = K_3;
        end
    end

    assign sum = {wa[WORD_W-6:0], wa[WORD_W-1:WORD_W-5]} + f_val + we_w + k_val + sched_word;

    // working variables
    always_ff @(posedge clk)
    begin
        if (ctrl.load_work)
        begin
            for (int i = 0; i < CHAIN_N; i++)
            begin
                work_reg[i] <= chain_reg[i];
            end
        end
        else if (ctrl.round_en)
        begin
            work_reg[0] <= sum;
            work_reg[1] <= wa;
            work_reg[2] <= {wb[1:0], wb[WORD_W-1:2]};
            work_reg[3] <= wc;
            work_reg[4] <= wd;
        end
    end

    // chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0] <= IV_0;
            chain_reg[1] <= IV_1;
            chain_reg[2] <= IV_2;
            chain_reg[3] <= IV_3;
            chain_reg[4] <= IV_4;
        end
        else if (ctrl.restore_iv)
        begin
            chain_reg[0] <= IV_0;
            chain_reg[1] <= IV_1;
            chain_reg[2] <= IV_2;
            chain_reg[3] <= IV_3;
            chain_reg[4] <= IV_4;
        end
        else if (ctrl.add_chain)
        begin
            for (int i = 0; i < CHAIN_N; i++)
            begin
                chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    // digest word select
    always_comb
    begin
        unique case (out_sel)
            3'd0:    chain_word = chain_reg[0];
            3'd1:    chain_word = chain_reg[1];
            3'd2:    chain_word = chain_reg[2];
            3'd3:    chain_word = chain_reg[3];
            default: chain_word = chain_reg[4];
        endcase
    end

endmodule

### src/sha1_byte_stream_hasher_top.sv
// top level: byte packing, padding sequencer, schedule memories, digest output
//
// SHA-1 over a byte stream. A transaction carries at most one message byte and may
// end the message. Bytes are taken one per cycle while idle and packed four to a word
// into the 16-word schedule memory (two copies, so four schedule taps are read each cycle).
// Every 64th byte starts a compression (80 rounds, one per cycle, then pipeline drain
// and chaining add) during which no byte is taken. An ending transaction adds padding
// writes and one compression, or padding writes and two compressions when more than
// 55 bytes are pending, and then the digest leaves as five transactions, word 0
// first, after which the hasher is back at its initial values. No byte is taken
// while the digest is pending.
module sha1_byte_stream_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        msg_end,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        word_last
);
    import sha1bsh_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_PAD    = 4'd1;
    localparam logic [3:0] S_ZERO   = 4'd2;
    localparam logic [3:0] S_LEN_HI = 4'd3;
    localparam logic [3:0] S_LEN_LO = 4'd4;
    localparam logic [3:0] S_ROUND  = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_FINAL  = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    // padding progress
    localparam logic [1:0] PST_NONE  = 2'd0;
    localparam logic [1:0] PST_EXTRA = 2'd1;
    localparam logic [1:0] PST_TAIL  = 2'd2;
    localparam logic [1:0] PST_LAST  = 2'd3;

    logic [3:0]         state_reg, state_next;
    logic [5:0]         fill_reg, fill_next;
    logic [23:0]        pack_reg, pack_next;
    logic [63:0]        len_reg, len_next;
    logic [4:0]         ptr_reg, ptr_next;
    logic               end_reg, end_next;
    logic [1:0]         pst_reg, pst_next;
    logic [ROUND_W-1:0] rnd_reg, rnd_next;
    logic [ROUND_W-1:0] rq_reg, rq_next;
    logic               rv_reg, rv_next;
    logic [2:0]         idx_reg, idx_next;

    logic                fsm_we;
    logic [SCHED_AW-1:0] fsm_waddr;
    logic [WORD_W-1:0]   fsm_wdata;
    logic                ram_we;
    logic [SCHED_AW-1:0] ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [WORD_W-1:0]   sched_word;
    sched_taps_t         taps;
    core_ctrl_t          ctrl;
    logic                accept;
    logic [WORD_W-1:0]   pad_word;
    logic [4:0]          zero_limit;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign digest_valid = (state_reg == S_OUT);
    assign word_index   = idx_reg;
    assign word_last    = (idx_reg == 3'd4);

    // word holding the pending bytes and the pad marker
    always_comb
    begin
        unique case (fill_reg[1:0])
            2'd0: pad_word = {PAD_BYTE, 24'h0};
            2'd1: pad_word = {pack_reg[7:0], PAD_BYTE, 16'h0};
            2'd2: pad_word = {pack_reg[15:0], PAD_BYTE, 8'h0};
            2'd3: pad_word = {pack_reg[23:0], PAD_BYTE};
        endcase
    end

    assign zero_limit = (pst_reg == PST_EXTRA) ? 5'd16 : 5'd14;

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        pack_next  = pack_reg;
        len_next   = len_reg;
        ptr_next   = ptr_reg;
        end_next   = end_reg;
        pst_next   = pst_reg;
        rnd_next   = rnd_reg;
        rq_next    = rq_reg;
        rv_next    = 1'b0;
        idx_next   = idx_reg;
        fsm_we     = 1'b0;
        fsm_waddr  = fill_reg[5:2];
        fsm_wdata  = {pack_reg, data_byte};
        ctrl       = '0;
        ctrl.round_en  = rv_reg;
        ctrl.round_idx = rq_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (byte_valid)
                    begin
                        pack_next = {pack_reg[15:0], data_byte};
                        fill_next = fill_reg + 6'd1;
                        len_next  = len_reg + 64'd8;
                        fsm_we    = (fill_reg[1:0] == 2'd3);
                        if (fill_reg == 6'd63)
                        begin
                            end_next   = msg_end;
                            state_next = S_ROUND;
                        end
                        else if (msg_end)
                        begin
                            end_next   = 1'b1;
                            state_next = S_PAD;
                        end
                    end
                    else if (msg_end)
                    begin
                        end_next   = 1'b1;
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                fsm_we     = 1'b1;
                fsm_wdata  = pad_word;
                ptr_next   = {1'b0, fill_reg[5:2]} + 5'd1;
                pst_next   = (fill_reg[5:3] == 3'b111) ? PST_EXTRA : PST_TAIL;
                state_next = S_ZERO;
            end
            S_ZERO:
            begin
                if (ptr_reg == zero_limit)
                begin
                    state_next = (pst_reg == PST_EXTRA) ? S_ROUND : S_LEN_HI;
                end
                else
                begin
                    fsm_we    = 1'b1;
                    fsm_waddr = ptr_reg[SCHED_AW-1:0];
                    fsm_wdata = '0;
                    ptr_next  = ptr_reg + 5'd1;
                end
            end
            S_LEN_HI:
            begin
                fsm_we     = 1'b1;
                fsm_waddr  = 4'd14;
                fsm_wdata  = len_reg[63:32];
                state_next = S_LEN_LO;
            end
            S_LEN_LO:
            begin
                fsm_we     = 1'b1;
                fsm_waddr  = 4'd15;
                fsm_wdata  = len_reg[31:0];
                pst_next   = PST_LAST;
                state_next = S_ROUND;
            end
            S_ROUND:
            begin
                ctrl.load_work = (rnd_reg == '0);
                rv_next = 1'b1;
                rq_next = rnd_reg;
                if (rnd_reg == ROUND_LAST)
                begin
                    rnd_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    rnd_next = rnd_reg + 7'd1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINAL;
            end
            S_FINAL:
            begin
                ctrl.add_chain = 1'b1;
                if (!end_reg)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    unique case (pst_reg)
                        PST_NONE:  state_next = S_PAD;
                        PST_EXTRA:
                        begin
                            ptr_next   = '0;
                            pst_next   = PST_TAIL;
                            state_next = S_ZERO;
                        end
                        PST_LAST:  state_next = S_OUT;
                        default:   state_next = S_IDLE;
                    endcase
                end
            end
            S_OUT:
            begin
                if (digest_ready)
                begin
                    if (idx_reg == 3'd4)
                    begin
                        ctrl.restore_iv = 1'b1;
                        idx_next   = '0;
                        fill_next  = '0;
                        len_next   = '0;
                        end_next   = 1'b0;
                        pst_next   = PST_NONE;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fill_reg  <= '0;
            len_reg   <= '0;
            ptr_reg   <= '0;
            end_reg   <= 1'b0;
            pst_reg   <= PST_NONE;
            rnd_reg   <= '0;
            rq_reg    <= '0;
            rv_reg    <= 1'b0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            len_reg   <= len_next;
            ptr_reg   <= ptr_next;
            end_reg   <= end_next;
            pst_reg   <= pst_next;
            rnd_reg   <= rnd_next;
            rq_reg    <= rq_next;
            rv_reg    <= rv_next;
            idx_reg   <= idx_next;
        end
    end

    // partial word bytes
    always_ff @(posedge clk)
    begin
        pack_reg <= pack_next;
    end

    // schedule write: expanded words during rounds, otherwise the sequencer
    assign ram_we    = rv_reg ? (rq_reg >= 7'd16) : fsm_we;
    assign ram_waddr = rv_reg ? rq_reg[SCHED_AW-1:0] : fsm_waddr;
    assign ram_wdata = rv_reg ? sched_word : fsm_wdata;

    sha1bsh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SCHED_DEPTH)
    ) u_sched_lo (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (rnd_reg[SCHED_AW-1:0] + 4'd13),
        .raddr_b (rnd_reg[SCHED_AW-1:0] + 4'd8),
        .rdata_a (taps[0]),
        .rdata_b (taps[1])
    );

    sha1bsh_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SCHED_DEPTH)
    ) u_sched_hi (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (rnd_reg[SCHED_AW-1:0] + 4'd2),
        .raddr_b (rnd_reg[SCHED_AW-1:0]),
        .rdata_a (taps[2]),
        .rdata_b (taps[3])
    );

    sha1bsh_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .taps       (taps),
        .out_sel    (idx_reg),
        .sched_word (sched_word),
        .chain_word (digest_word)
    );

    // checks
    a_no_take_while_digest: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> !item_ready)
        else $error("byte taken while digest pending");

    a_round_stage_in_compress: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg |-> (state_reg == S_ROUND || state_reg == S_DRAIN))
        else $error("round data stage outside compression");

    a_drain_has_round: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DRAIN) |-> (rv_reg && rq_reg == ROUND_LAST))
        else $error("drain without final round");

    a_word_index_range: assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (idx_reg <= 3'd4))
        else $error("digest word index out of range");

    a_out_after_length: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(digest_valid) |-> ($past(state_reg) == S_FINAL && pst_reg == PST_LAST))
        else $error("digest shown before length block");

endmodule
